// ----- rtl/core/tty_line_discipline_macros.svh -----
// assertion helpers for the line discipline checker
`ifndef TTY_LINE_DISCIPLINE_MACROS_SVH
`define TTY_LINE_DISCIPLINE_MACROS_SVH

// clocked assertion, off while in reset
`define TLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same-cycle implication
`define TLD_ASSERT_IMP(lbl, ante, cons, msg) \
  `TLD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- rtl/core/tld_pkg.sv -----
`timescale 1ns / 1ps
package tld_pkg;

  localparam int LINE_DEPTH_DEF = 256;
  localparam int CFG_AW         = 3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MODE  = 3'd0,
    CFG_STOP  = 3'd1,
    CFG_START = 3'd2,
    CFG_ERASE = 3'd3,
    CFG_EOF   = 3'd4,
    CFG_INTR  = 3'd5,
    CFG_QUIT  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_ECHO  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_READ = 1'b1
  } op_t;

  localparam logic [7:0] CH_CR       = 8'd13;
  localparam logic [7:0] CH_LF       = 8'd10;
  localparam logic [7:0] CH_BS       = 8'd8;
  localparam logic [7:0] CH_SP       = 8'd32;
  localparam logic [7:0] CH_CARET    = 8'd94;
  localparam logic [7:0] CTRL_OFFSET = 8'd64;
  localparam logic [7:0] CTRL_LIMIT  = 8'd32;

  localparam logic [7:0] MODE_RST  = 8'd237;
  localparam logic [7:0] STOP_RST  = 8'd26;
  localparam logic [7:0] START_RST = 8'd19;
  localparam logic [7:0] ERASE_RST = 8'o177;
  localparam logic [7:0] EOF_RST   = 8'd4;
  localparam logic [7:0] INTR_RST  = 8'd3;
  localparam logic [7:0] QUIT_RST  = 8'd28;

  typedef struct packed {
    logic echoctl;
    logic echoe;
    logic echo;
    logic ignbrk;
    logic isig;
    logic icanon;
    logic igncr;
    logic icrnl;
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] stop_c;
    logic [7:0] start_c;
    logic [7:0] erase_c;
    logic [7:0] eof_c;
    logic [7:0] intr_c;
    logic [7:0] quit_c;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] last_idx;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       wake;
  } bundle_t;

  typedef struct packed {
    bundle_t res;
    logic    push;
    logic    erase;
  } decode_t;

endpackage

// ----- rtl/core/tld_if.sv -----
`timescale 1ns / 1ps
interface tld_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface tld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       wake;
  logic       line_end;
  logic       last;

  modport source (output valid, output kind, output out_byte, output wake,
                  output line_end, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input wake,
                  input line_end, input last, output ready);
endinterface

// ----- rtl/core/tld_store.sv -----
`timescale 1ns / 1ps
module tld_store #(
  parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF,
  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);
  import tld_pkg::*;

  logic [7:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/tld_decode.sv -----
`timescale 1ns / 1ps
module tld_decode (
  input  logic             op,
  input  logic [7:0]       data_byte,
  input  tld_pkg::cfg_t    cfg,
  input  logic             store_empty,
  output tld_pkg::decode_t dec
);
  import tld_pkg::*;

  logic [7:0] c;
  logic       drop;
  logic       wake;
  logic       push;
  logic       erase;
  logic [1:0] n;
  logic [7:0] e0;
  logic [7:0] e1;
  logic [7:0] e2;

  // translate, filter and build the echo sequence
  always_comb begin
    c     = data_byte;
    drop  = 1'b0;
    wake  = 1'b0;
    push  = 1'b0;
    erase = 1'b0;
    n     = 2'd0;
    e0    = 8'd0;
    e1    = 8'd0;
    e2    = 8'd0;
    if (c == CH_CR) begin
      if (cfg.mode.icrnl) begin
        c = CH_LF;
      end else if (cfg.mode.igncr) begin
        drop = 1'b1;
      end
    end
    if (!drop) begin
      if (cfg.mode.icanon) begin
        if (c == cfg.stop_c || c == cfg.start_c || c == cfg.erase_c) begin
          drop = 1'b1;
        end else if (c == CH_LF || c == cfg.eof_c) begin
          wake = 1'b1;
        end
      end else begin
        wake = 1'b1;
      end
    end
    if (!drop && (!cfg.mode.isig || cfg.mode.ignbrk) &&
        (c == cfg.intr_c || c == cfg.quit_c)) begin
      drop = 1'b1;
    end
    if (!drop) begin
      push = 1'b1;
      if (cfg.mode.echo) begin
        if (c == CH_LF) begin
          n  = 2'd2;
          e0 = CH_CR;
          e1 = CH_LF;
        end else if (c == CH_BS && cfg.mode.echoe) begin
          push = 1'b0;
          if (!store_empty) begin
            n     = 2'd3;
            e0    = CH_BS;
            e1    = CH_SP;
            e2    = CH_BS;
            erase = 1'b1;
          end
        end else if (c < CTRL_LIMIT) begin
          if (cfg.mode.echoctl) begin
            n  = 2'd2;
            e0 = CH_CARET;
            e1 = c + CTRL_OFFSET;
          end
        end else begin
          n  = 2'd1;
          e0 = c;
        end
      end
    end
  end

  always_comb begin
    dec = '0;
    if (op == OP_READ) begin
      dec.res.kind = store_empty ? KIND_EMPTY : KIND_READ;
    end else begin
      dec.res.kind     = (n == 2'd0) ? KIND_NONE : KIND_ECHO;
      dec.res.last_idx = (n == 2'd0) ? 2'd0 : n - 2'd1;
      dec.res.b0       = e0;
      dec.res.b1       = e1;
      dec.res.b2       = e2;
      dec.res.wake     = wake;
      dec.push         = push;
      dec.erase        = erase;
    end
  end

endmodule

// ----- rtl/core/tty_line_discipline.sv -----
`timescale 1ns / 1ps
// Terminal line discipline. A receive item (op 0) carries one typed byte that is
// translated, filtered, echoed and put in a ring line store of LINE_DEPTH bytes
// (it holds LINE_DEPTH-1; a byte arriving when full is dropped). A read item
// (op 1) takes one byte out of the store. Each item yields one to three result
// items, the final one marked by last. An accepted item waits in the input
// register, where it is decoded and the line store is read, until the result
// register is free, then moves to the result register. The result register
// holds an item until all its results are taken, offering them in order; a
// newline, control byte or erase echo gives more than one result. A new item
// is accepted when the input register is empty or moving on. The store has no
// clearing pass; only written entries are ever read.
module tty_line_discipline #(
  parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tld_in_if.sink                    in_ch,
  tld_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [tld_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [7:0]                cfg_wdata
);
  import tld_pkg::*;

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam logic [AW-1:0] IDX_LAST = AW'(LINE_DEPTH - 1);

  cfg_t          cfg_r, cfg_nxt;
  logic          a_valid_r, a_valid_nxt;
  logic          a_op_r, a_op_nxt;
  logic [7:0]    a_byte_r, a_byte_nxt;
  logic          b_valid_r, b_valid_nxt;
  logic [1:0]    beat_r, beat_nxt;
  bundle_t       bun_r, bun_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;

  logic          accept;
  logic          a_fire;
  logic          b_last;
  logic          b_free;
  logic          out_fire;
  logic          store_empty;
  logic          store_full;
  logic [AW-1:0] wr_inc;
  logic [AW-1:0] wr_dec;
  logic [AW-1:0] rd_inc;
  logic          store_we;
  logic [7:0]    rdata;
  decode_t       dec;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_MODE:  cfg_nxt.mode    = mode_t'(cfg_wdata);
        CFG_STOP:  cfg_nxt.stop_c  = cfg_wdata;
        CFG_START: cfg_nxt.start_c = cfg_wdata;
        CFG_ERASE: cfg_nxt.erase_c = cfg_wdata;
        CFG_EOF:   cfg_nxt.eof_c   = cfg_wdata;
        CFG_INTR:  cfg_nxt.intr_c  = cfg_wdata;
        CFG_QUIT:  cfg_nxt.quit_c  = cfg_wdata;
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  assign store_empty = (wr_idx_r == rd_idx_r);
  assign wr_inc      = (wr_idx_r == IDX_LAST) ? '0 : wr_idx_r + 1'b1;
  assign wr_dec      = (wr_idx_r == '0) ? IDX_LAST : wr_idx_r - 1'b1;
  assign rd_inc      = (rd_idx_r == IDX_LAST) ? '0 : rd_idx_r + 1'b1;
  assign store_full  = (wr_inc == rd_idx_r);

  assign b_last   = (beat_r == bun_r.last_idx);
  assign out_fire = b_valid_r && out_ch.ready;
  assign b_free   = !b_valid_r || (out_ch.ready && b_last);
  assign a_fire   = a_valid_r && b_free;
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !a_valid_r || b_free;

  tld_decode u_decode (
    .op          (a_op_r),
    .data_byte   (a_byte_r),
    .cfg         (cfg_r),
    .store_empty (store_empty),
    .dec         (dec)
  );

  assign store_we = a_fire && dec.push && !store_full;

  tld_store #(.LINE_DEPTH(LINE_DEPTH)) u_store (
    .clk     (clk),
    .we      (store_we),
    .waddr   (wr_idx_r),
    .wdata   (a_byte_r == CH_CR && cfg_r.mode.icrnl ? CH_LF : a_byte_r),
    .re      (a_fire),
    .raddr   (rd_idx_r),
    .rdata_r (rdata)
  );

  always_comb begin
    a_valid_nxt = a_valid_r;
    a_op_nxt    = a_op_r;
    a_byte_nxt  = a_byte_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
      a_op_nxt    = in_ch.op;
      a_byte_nxt  = in_ch.data_byte;
    end else if (a_fire) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    beat_nxt    = beat_r;
    bun_nxt     = bun_r;
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    if (a_fire) begin
      b_valid_nxt = 1'b1;
      beat_nxt    = 2'd0;
      bun_nxt     = dec.res;
      if (dec.erase) begin
        wr_idx_nxt = wr_dec;
      end else if (store_we) begin
        wr_idx_nxt = wr_inc;
      end
      if (dec.res.kind == KIND_READ) begin
        rd_idx_nxt = rd_inc;
      end
    end else if (out_fire) begin
      if (b_last) begin
        b_valid_nxt = 1'b0;
      end else begin
        beat_nxt = beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= {MODE_RST, STOP_RST, START_RST, ERASE_RST, EOF_RST, INTR_RST, QUIT_RST};
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      beat_r    <= 2'd0;
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
    end else begin
      cfg_r     <= cfg_nxt;
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      beat_r    <= beat_nxt;
      wr_idx_r  <= wr_idx_nxt;
      rd_idx_r  <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_op_r   <= a_op_nxt;
    a_byte_r <= a_byte_nxt;
    bun_r    <= bun_nxt;
  end

  always_comb begin
    out_ch.out_byte = bun_r.b0;
    case (beat_r)
      2'd1:    out_ch.out_byte = bun_r.b1;
      2'd2:    out_ch.out_byte = bun_r.b2;
      default: out_ch.out_byte = bun_r.b0;
    endcase
    if (bun_r.kind == KIND_READ) begin
      out_ch.out_byte = rdata;
    end
  end

  assign out_ch.valid    = b_valid_r;
  assign out_ch.kind     = bun_r.kind;
  assign out_ch.wake     = bun_r.wake;
  assign out_ch.last     = b_last;
  assign out_ch.line_end = (bun_r.kind == KIND_READ) && cfg_r.mode.icanon &&
                           (rdata == CH_LF || rdata == cfg_r.eof_c);

endmodule

// ----- rtl/core/tld_checker.sv -----
`timescale 1ns / 1ps
`include "tty_line_discipline_macros.svh"
module tld_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_wake,
  input logic       out_line_end,
  input logic       out_last
);
  import tld_pkg::*;

  `TLD_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)), "stalled result changed")
  `TLD_ASSERT_IMP(a_read_single, out_valid && (out_kind == KIND_READ || out_kind == KIND_EMPTY), out_last && !out_wake, "read item gave more than one result or wake")
  `TLD_ASSERT_IMP(a_line_end_read, out_valid && out_line_end, out_kind == KIND_READ, "line end on a non-read result")
  `TLD_ASSERT_IMP(a_none_single, out_valid && out_kind == KIND_NONE, out_last && out_byte == 8'd0, "empty receive result malformed")
  `TLD_ASSERT_IMP(a_multi_echo, out_valid && !out_last, out_kind == KIND_ECHO, "non-final result is not an echo")

endmodule

bind tty_line_discipline tld_checker u_tld_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_byte     (out_ch.out_byte),
  .out_wake     (out_ch.wake),
  .out_line_end (out_ch.line_end),
  .out_last     (out_ch.last)
);
